@@ rtl/smp_pkg.sv @@
// Shared types, register indexes, reset values and unit codes for the stepper move profile.
package smp_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_TURN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_WIDTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_LIMIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MOVE         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSAL_WINDOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH_CHANGE = 3'd5;

   localparam logic [15:0] RESET_STEPS_PER_TURN   = 16'd6400;
   localparam logic [9:0]  RESET_BASE_WIDTH       = 10'd150;
   localparam logic [11:0] RESET_ACCEL_LIMIT      = 12'd800;
   localparam logic [9:0]  RESET_MIN_MOVE         = 10'd20;
   localparam logic [11:0] RESET_REVERSAL_WINDOW  = 12'd100;
   localparam logic [9:0]  RESET_MAX_WIDTH_CHANGE = 10'd50;

   localparam logic [11:0] WIDTH_MAX = 12'hFFF;

   // Arithmetic unit sizes: cube of a 12-bit count, times a 10-bit base width.
   localparam int DEN_W  = 36;
   localparam int MULB_W = 12;
   localparam int ACC_W  = DEN_W + MULB_W;
   localparam int QUOT_W = 10;
   localparam int DVS_W  = DEN_W + QUOT_W - 1;
   localparam int CNT_W  = $clog2(QUOT_W);

   localparam logic [1:0] ALU_NOP     = 2'd0;
   localparam logic [1:0] ALU_MUL     = 2'd1;
   localparam logic [1:0] ALU_SETD    = 2'd2;
   localparam logic [1:0] ALU_DIVSTEP = 2'd3;

   typedef struct packed {
      logic [15:0] steps_per_turn;
      logic [9:0]  base_width;
      logic [11:0] accel_limit;
      logic [9:0]  min_move;
      logic [11:0] reversal_window;
      logic [9:0]  max_width_change;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [DEN_W-1:0]  opa;
      logic [MULB_W-1:0] opb;
   } alu_cmd_type;

   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic [QUOT_W-1:0] quot;
   } alu_res_type;

endpackage

@@ rtl/smp_csr.sv @@
// Configuration registers of the stepper move profile with their write decode.
module smp_csr
   import smp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STEPS_PER_TURN:   cfg_in.steps_per_turn   = csr_wdata;
            CSR_BASE_WIDTH:       cfg_in.base_width       = csr_wdata[9:0];
            CSR_ACCEL_LIMIT:      cfg_in.accel_limit      = csr_wdata[11:0];
            CSR_MIN_MOVE:         cfg_in.min_move         = csr_wdata[9:0];
            CSR_REVERSAL_WINDOW:  cfg_in.reversal_window  = csr_wdata[11:0];
            CSR_MAX_WIDTH_CHANGE: cfg_in.max_width_change = csr_wdata[9:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_turn   <= RESET_STEPS_PER_TURN;
         cfg_ff.base_width       <= RESET_BASE_WIDTH;
         cfg_ff.accel_limit      <= RESET_ACCEL_LIMIT;
         cfg_ff.min_move         <= RESET_MIN_MOVE;
         cfg_ff.reversal_window  <= RESET_REVERSAL_WINDOW;
         cfg_ff.max_width_change <= RESET_MAX_WIDTH_CHANGE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/smp_alu.sv @@
// Shared arithmetic unit: registered multiplier and restoring division step.
module smp_alu
   import smp_pkg::*;
(
   input  logic        clock,
   input  alu_cmd_type cmd,
   output alu_res_type res
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [ACC_W-1:0]  prod;
   logic [ACC_W-1:0]  dvs_ext;
   logic              ge;

   assign prod    = {{MULB_W{1'b0}}, cmd.opa} * {{DEN_W{1'b0}}, cmd.opb};
   assign dvs_ext = {{(ACC_W-DVS_W){1'b0}}, dvs_ff};
   assign ge      = acc_ff >= dvs_ext;

   always_comb begin
      acc_in  = acc_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      unique case (cmd.op)
         ALU_MUL: begin
            acc_in = prod;
         end
         ALU_SETD: begin
            dvs_in  = {cmd.opa, {(QUOT_W-1){1'b0}}};
            quot_in = '0;
         end
         ALU_DIVSTEP: begin
            if (ge) begin
               acc_in = acc_ff - dvs_ext;
            end
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            dvs_in  = dvs_ff >> 1;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign res.acc  = acc_ff;
   assign res.quot = quot_ff;

endmodule

@@ rtl/stepper_move_profile_core.sv @@
// Top level of the stepper move profile: sequencer, move state and result register.
// A new transaction is accepted only in idle: a target transaction, a tick outside a move,
// a cruise step and a ramp step each finish before the next transaction is accepted.
// A ramp step makes five passes through the shared 36x12 multiplier and ten steps of the
// restoring divider. Each result is registered once the work ends.
// Synchronous reset restores the register defaults, position 0 and no move in progress.
module stepper_move_profile_core
   import smp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [15:0]           req_target_step,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic                  rsp_direction,
   output logic                  rsp_step_valid,
   output logic [11:0]           rsp_pulse_width,
   output logic [10:0]           rsp_half_period,
   output logic [15:0]           rsp_position,
   output logic                  rsp_move_done,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PLAN  = 4'd1;
   localparam logic [3:0] ST_TICK  = 4'd2;
   localparam logic [3:0] ST_M_AA  = 4'd3;
   localparam logic [3:0] ST_M_AAA = 4'd4;
   localparam logic [3:0] ST_M_JJ  = 4'd5;
   localparam logic [3:0] ST_M_JJJ = 4'd6;
   localparam logic [3:0] ST_M_BJ  = 4'd7;
   localparam logic [3:0] ST_D_SET = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;

   localparam logic [1:0] MODE_CRUISE = 2'd0;
   localparam logic [1:0] MODE_ACCEL  = 2'd1;
   localparam logic [1:0] MODE_DECEL  = 2'd2;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   localparam logic CMD_TICK = 1'b1;

   cfg_type     cfg;
   alu_cmd_type alu_cmd;
   alu_res_type alu_res;

   smp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   smp_alu u_alu (
      .clock (clock),
      .cmd   (alu_cmd),
      .res   (alu_res)
   );

   logic [3:0]       state_ff, state_in;
   logic [15:0]      pos_ff, pos_in;
   logic [1:0]       last_dir_ff, last_dir_in;
   logic [11:0]      cw_ff, cw_in;
   logic             moving_ff, moving_in;
   logic             mdir_ff, mdir_in;
   logic [15:0]      sidx_ff, sidx_in;
   logic [15:0]      total_ff, total_in;
   logic [11:0]      ramp_ff, ramp_in;
   logic [15:0]      target_ff, target_in;
   logic [1:0]       mode_ff, mode_in;
   logic [11:0]      j_ff, j_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_accepted_ff, rsp_accepted_in;
   logic        rsp_direction_ff, rsp_direction_in;
   logic        rsp_step_valid_ff, rsp_step_valid_in;
   logic [11:0] rsp_pulse_width_ff, rsp_pulse_width_in;
   logic [15:0] rsp_position_ff, rsp_position_in;
   logic        rsp_move_done_ff, rsp_move_done_in;

   logic        out_free;

   // Move planning.
   logic        p_fwd_raw;
   logic [15:0] p_dist;
   logic [1:0]  p_dcode;
   logic        p_fwd;
   logic [15:0] p_total;
   logic        p_ok;
   logic [14:0] p_half;
   logic [11:0] p_ramp;

   // Step profile.
   logic [15:0] d_start;
   logic [15:0] d_off;
   logic        t_accel;
   logic        t_decel;
   logic [10:0] q_ceil;
   logic [11:0] tgt;
   logic [11:0] w_diff;
   logic [12:0] w_slew;
   logic [11:0] new_w;
   logic [16:0] pos_inc;
   logic [15:0] pos_step;
   logic [15:0] sidx_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      p_fwd_raw = target_ff > pos_ff;
      p_dist    = p_fwd_raw ? (target_ff - pos_ff) : (pos_ff - target_ff);
      p_dcode   = p_fwd_raw ? DIR_FWD : DIR_REV;
      p_fwd     = p_fwd_raw;
      p_total   = p_dist;
      p_ok      = p_dist >= {6'b0, cfg.min_move};
      if (last_dir_ff != DIR_NONE && p_dcode != last_dir_ff &&
          p_dist < {4'b0, cfg.reversal_window}) begin
         p_fwd = (last_dir_ff == DIR_FWD);
      end
      if (p_dist > {1'b0, cfg.steps_per_turn[15:1]}) begin
         if (p_dist > cfg.steps_per_turn) begin
            p_ok = 1'b0;
         end else begin
            p_fwd   = !p_fwd;
            p_total = cfg.steps_per_turn - p_dist;
         end
      end
      p_half = p_total[15:1];
      p_ramp = ({4'b0, cfg.accel_limit} < {1'b0, p_half}) ? cfg.accel_limit : p_half[11:0];
   end

   always_comb begin
      d_start = total_ff - {4'b0, ramp_ff};
      d_off   = sidx_ff - d_start;
      t_accel = (ramp_ff != '0) && (sidx_ff < {4'b0, ramp_ff});
      t_decel = (ramp_ff != '0) && !t_accel && (sidx_ff >= d_start);

      q_ceil = {1'b0, alu_res.quot} + {10'b0, (alu_res.acc != '0)};
      case (mode_ff)
         MODE_ACCEL: tgt = {1'b0, cfg.base_width, 1'b0} - {1'b0, q_ceil};
         MODE_DECEL: tgt = {2'b0, cfg.base_width} + {2'b0, alu_res.quot};
         default:    tgt = {2'b0, cfg.base_width};
      endcase

      w_diff = (tgt > cw_ff) ? (tgt - cw_ff) : (cw_ff - tgt);
      if (w_diff > {2'b0, cfg.max_width_change}) begin
         if (tgt < cw_ff) begin
            w_slew = {1'b0, cw_ff} - {3'b0, cfg.max_width_change};
         end else begin
            w_slew = {1'b0, cw_ff} + {3'b0, cfg.max_width_change};
         end
      end else begin
         w_slew = {1'b0, tgt};
      end
      new_w = w_slew[12] ? WIDTH_MAX : w_slew[11:0];

      pos_inc = {1'b0, pos_ff} + 17'd1;
      if (mdir_ff) begin
         pos_step = (pos_inc >= {1'b0, cfg.steps_per_turn}) ? 16'd0 : pos_inc[15:0];
      end else begin
         pos_step = (pos_ff == '0) ? (cfg.steps_per_turn - 16'd1) : (pos_ff - 16'd1);
      end
      sidx_next = sidx_ff + 16'd1;
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      last_dir_in = last_dir_ff;
      cw_in       = cw_ff;
      moving_in   = moving_ff;
      mdir_in     = mdir_ff;
      sidx_in     = sidx_ff;
      total_in    = total_ff;
      ramp_in     = ramp_ff;
      target_in   = target_ff;
      mode_in     = mode_ff;
      j_in        = j_ff;
      den_in      = den_ff;
      cnt_in      = cnt_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_accepted_in    = rsp_accepted_ff;
      rsp_direction_in   = rsp_direction_ff;
      rsp_step_valid_in  = rsp_step_valid_ff;
      rsp_pulse_width_in = rsp_pulse_width_ff;
      rsp_position_in    = rsp_position_ff;
      rsp_move_done_in   = rsp_move_done_ff;

      alu_cmd.op  = ALU_NOP;
      alu_cmd.opa = '0;
      alu_cmd.opb = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               target_in = req_target_step;
               state_in  = (req_cmd == CMD_TICK) ? ST_TICK : ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (out_free) begin
               if (!moving_ff && p_ok) begin
                  mdir_in     = p_fwd;
                  last_dir_in = p_fwd ? DIR_FWD : DIR_REV;
                  total_in    = p_total;
                  ramp_in     = p_ramp;
                  sidx_in     = '0;
                  moving_in   = (p_total != '0);
               end
               rsp_valid_in       = 1'b1;
               rsp_accepted_in    = !moving_ff && p_ok;
               rsp_direction_in   = (!moving_ff && p_ok) ? p_fwd : mdir_ff;
               rsp_step_valid_in  = 1'b0;
               rsp_pulse_width_in = '0;
               rsp_position_in    = pos_ff;
               rsp_move_done_in   = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (!moving_ff) begin
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_accepted_in    = 1'b0;
                  rsp_direction_in   = mdir_ff;
                  rsp_step_valid_in  = 1'b0;
                  rsp_pulse_width_in = '0;
                  rsp_position_in    = pos_ff;
                  rsp_move_done_in   = 1'b0;
                  state_in           = ST_IDLE;
               end
            end else begin
               mode_in  = t_accel ? MODE_ACCEL : (t_decel ? MODE_DECEL : MODE_CRUISE);
               j_in     = t_accel ? sidx_ff[11:0] : d_off[11:0];
               state_in = (t_accel || t_decel) ? ST_M_AA : ST_FIN;
            end
         end
         ST_M_AA: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = {{(DEN_W-12){1'b0}}, ramp_ff};
            alu_cmd.opb = ramp_ff;
            state_in    = ST_M_AAA;
         end
         ST_M_AAA: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = alu_res.acc[DEN_W-1:0];
            alu_cmd.opb = ramp_ff;
            state_in    = ST_M_JJ;
         end
         ST_M_JJ: begin
            den_in      = alu_res.acc[DEN_W-1:0];
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = {{(DEN_W-12){1'b0}}, j_ff};
            alu_cmd.opb = j_ff;
            state_in    = ST_M_JJJ;
         end
         ST_M_JJJ: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = alu_res.acc[DEN_W-1:0];
            alu_cmd.opb = j_ff;
            state_in    = ST_M_BJ;
         end
         ST_M_BJ: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = alu_res.acc[DEN_W-1:0];
            alu_cmd.opb = {2'b0, cfg.base_width};
            state_in    = ST_D_SET;
         end
         ST_D_SET: begin
            alu_cmd.op  = ALU_SETD;
            alu_cmd.opa = den_ff;
            cnt_in      = CNT_W'(QUOT_W - 1);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            alu_cmd.op = ALU_DIVSTEP;
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cw_in     = new_w;
               pos_in    = pos_step;
               sidx_in   = sidx_next;
               moving_in = !(sidx_next >= total_ff);

               rsp_valid_in       = 1'b1;
               rsp_accepted_in    = 1'b0;
               rsp_direction_in   = mdir_ff;
               rsp_step_valid_in  = 1'b1;
               rsp_pulse_width_in = new_w;
               rsp_position_in    = pos_step;
               rsp_move_done_in   = (sidx_next >= total_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         last_dir_ff  <= DIR_NONE;
         cw_ff        <= {2'b0, RESET_BASE_WIDTH};
         moving_ff    <= 1'b0;
         mdir_ff      <= 1'b0;
         sidx_ff      <= '0;
         total_ff     <= '0;
         ramp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         last_dir_ff  <= last_dir_in;
         cw_ff        <= cw_in;
         moving_ff    <= moving_in;
         mdir_ff      <= mdir_in;
         sidx_ff      <= sidx_in;
         total_ff     <= total_in;
         ramp_ff      <= ramp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff          <= target_in;
      mode_ff            <= mode_in;
      j_ff               <= j_in;
      den_ff             <= den_in;
      cnt_ff             <= cnt_in;
      rsp_accepted_ff    <= rsp_accepted_in;
      rsp_direction_ff   <= rsp_direction_in;
      rsp_step_valid_ff  <= rsp_step_valid_in;
      rsp_pulse_width_ff <= rsp_pulse_width_in;
      rsp_position_ff    <= rsp_position_in;
      rsp_move_done_ff   <= rsp_move_done_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_direction   = rsp_direction_ff;
   assign rsp_step_valid  = rsp_step_valid_ff;
   assign rsp_pulse_width = rsp_pulse_width_ff;
   assign rsp_half_period = rsp_pulse_width_ff[11:1];
   assign rsp_position    = rsp_position_ff;
   assign rsp_move_done   = rsp_move_done_ff;

   a_moving_has_steps: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (total_ff != '0))
      else $error("A move is running with no steps planned.");

   a_index_in_move: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (sidx_ff < total_ff))
      else $error("The step index ran past the end of the move.");

   a_ramp_fits: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> ({1'b0, ramp_ff} <= {1'b0, total_ff[15:1]}))
      else $error("The ramp is longer than half the move.");

   a_one_kind_of_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_step_valid))
      else $error("A result reports both a started move and a step.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("A transaction was accepted but no work started.");

endmodule

@@ tb/stepper_move_profile_core_tb.sv @@
// Testbench for the stepper move profile core: directed table, random move sequences, checks.
module stepper_move_profile_core_tb
   import smp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic CMD_TARGET = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int unsigned PHASE_ITEMS = 84;

   typedef enum logic [1:0] {
      LAST_NONE = 2'd0,
      LAST_FWD  = 2'd1,
      LAST_REV  = 2'd2
   } last_dir_type;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      logic        accepted;
      logic        direction;
      logic        step_valid;
      logic [11:0] pulse_width;
      logic [10:0] half_period;
      logic [15:0] position;
      logic        move_done;
   } step_result_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  cmd;
      logic [15:0]           word;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [7:0]            reps;
      logic                  has_want;
      step_result_type       want;
   } dir_row_type;

   localparam step_result_type ZERO_RESULT = '0;
   localparam step_result_type EMPTY_MOVE_RESULT = '{accepted: 1'b1, direction: 1'b0,
      step_valid: 1'b0, pulse_width: 12'd0, half_period: 11'd0, position: 16'd0,
      move_done: 1'b0};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = 1'b0;
   logic [15:0]           req_target_step = 16'd0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic                  rsp_direction;
   logic                  rsp_step_valid;
   logic [11:0]           rsp_pulse_width;
   logic [10:0]           rsp_half_period;
   logic [15:0]           rsp_position;
   logic                  rsp_move_done;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   step_result_type profile_q [$];
   int unsigned     fail_count = 0;
   logic            idle_on = 1'b1;

   cfg_type      prof_cfg;
   logic [15:0]  pos_q;
   last_dir_type last_dir;
   logic [11:0]  cur_width;
   logic         in_move;
   logic         move_dir;
   logic [15:0]  step_idx;
   logic [15:0]  total_len;
   logic [11:0]  ramp_len;

   dir_row_type dir_tab [19];
   cfg_type     phase_cfg [6];

   stepper_move_profile_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_target_step (req_target_step),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_direction   (rsp_direction),
      .rsp_step_valid  (rsp_step_valid),
      .rsp_pulse_width (rsp_pulse_width),
      .rsp_half_period (rsp_half_period),
      .rsp_position    (rsp_position),
      .rsp_move_done   (rsp_move_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("stepper_move_profile_core test failed");
      $finish;
   end

   function automatic int unsigned ramp_target(input int unsigned i);
      longint unsigned b, a, den, num, j, w;
      int unsigned     dstart;
      b = prof_cfg.base_width;
      a = ramp_len;
      den = a * a * a;
      dstart = int'(total_len) - int'(ramp_len);
      w = b;
      if (i < ramp_len && den != 0) begin
         j = i;
         num = b * j * j * j;
         w = 2 * b - (num + den - 1) / den;
      end else if (i >= dstart && den != 0) begin
         j = i - dstart;
         num = b * j * j * j;
         w = b + num / den;
      end
      return int'(w);
   endfunction

   function automatic step_result_type advance_profile(input logic cmd,
                                                       input logic [15:0] tgt);
      step_result_type r;
      int unsigned     total, half, t, diff, nxt;
      logic            fwd, ok;
      last_dir_type    dcode;
      r = '0;
      if (cmd == CMD_TARGET) begin
         if (!in_move) begin
            total = (tgt > pos_q) ? tgt - pos_q : pos_q - tgt;
            fwd = (tgt > pos_q);
            if (total >= prof_cfg.min_move) begin
               dcode = fwd ? LAST_FWD : LAST_REV;
               ok = 1'b1;
               if (last_dir != LAST_NONE && dcode != last_dir &&
                   total < prof_cfg.reversal_window)
                  fwd = (last_dir == LAST_FWD);
               if (total > prof_cfg.steps_per_turn / 2) begin
                  if (total > prof_cfg.steps_per_turn) begin
                     ok = 1'b0;
                  end else begin
                     fwd = !fwd;
                     total = prof_cfg.steps_per_turn - total;
                  end
               end
               if (ok) begin
                  half = total / 2;
                  r.accepted = 1'b1;
                  move_dir = fwd;
                  last_dir = fwd ? LAST_FWD : LAST_REV;
                  total_len = total[15:0];
                  ramp_len = (prof_cfg.accel_limit < half) ? prof_cfg.accel_limit
                                                           : half[11:0];
                  step_idx = 16'd0;
                  in_move = (total != 0);
               end
            end
         end
      end else if (in_move) begin
         t = ramp_target(step_idx);
         diff = (t > cur_width) ? t - cur_width : cur_width - t;
         if (diff > prof_cfg.max_width_change) begin
            if (t < cur_width) t = cur_width - prof_cfg.max_width_change;
            else t = cur_width + prof_cfg.max_width_change;
         end
         if (t > WIDTH_MAX) t = WIDTH_MAX;
         cur_width = t[11:0];
         r.step_valid = 1'b1;
         r.pulse_width = t[11:0];
         r.half_period = t[11:1];
         if (move_dir) begin
            nxt = pos_q + 1;
            pos_q = (nxt >= prof_cfg.steps_per_turn) ? 16'd0 : nxt[15:0];
         end else if (pos_q == 16'd0) begin
            pos_q = prof_cfg.steps_per_turn - 16'd1;
         end else begin
            pos_q = pos_q - 16'd1;
         end
         step_idx = step_idx + 16'd1;
         if (step_idx >= total_len) begin
            r.move_done = 1'b1;
            in_move = 1'b0;
         end
      end
      r.direction = move_dir;
      r.position = pos_q;
      return r;
   endfunction

   task automatic send_item(input logic cmd, input logic [15:0] tgt,
                            input logic has_want, input step_result_type want);
      step_result_type predicted;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      predicted = advance_profile(cmd, tgt);
      profile_q.push_back(has_want ? want : predicted);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_target_step <= tgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (profile_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEPS_PER_TURN:   prof_cfg.steps_per_turn = data;
         CSR_BASE_WIDTH:       prof_cfg.base_width = data[9:0];
         CSR_ACCEL_LIMIT:      prof_cfg.accel_limit = data[11:0];
         CSR_MIN_MOVE:         prof_cfg.min_move = data[9:0];
         CSR_REVERSAL_WINDOW:  prof_cfg.reversal_window = data[11:0];
         CSR_MAX_WIDTH_CHANGE: prof_cfg.max_width_change = data[9:0];
         default: ;
      endcase
   endtask

   // Picks a target at distance d from the current position, falling back to distance k.
   function automatic logic [15:0] aim_target(input int d, input int k);
      int p, t;
      p = int'(pos_q);
      t = ($urandom_range(1) != 0) ? p + d : p - d;
      if (t < 0 || t > 65535) t = (t == p + d) ? p - d : p + d;
      if (t < 0 || t > 65535) t = (p + k > 65535) ? p - k : p + k;
      return t[15:0];
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 14);
   end

   always @(posedge clock) begin : check_results
      step_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (profile_q.size() == 0) begin
            $display("%0t: unexpected result transaction, position %0d", $time,
                     rsp_position);
            fail_count++;
         end else begin
            want = profile_q.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("direction", want.direction, rsp_direction);
            check_field("step_valid", want.step_valid, rsp_step_valid);
            check_field("pulse_width", want.pulse_width, rsp_pulse_width);
            check_field("half_period", want.half_period, rsp_half_period);
            check_field("position", want.position, rsp_position);
            check_field("move_done", want.move_done, rsp_move_done);
         end
      end
   end

   initial begin : stimulus
      int unsigned ph, n, r, roll, kmax, lo, k;
      logic [15:0] junk;
      cfg_type     pc;

      prof_cfg = '{steps_per_turn: RESET_STEPS_PER_TURN, base_width: RESET_BASE_WIDTH,
                   accel_limit: RESET_ACCEL_LIMIT, min_move: RESET_MIN_MOVE,
                   reversal_window: RESET_REVERSAL_WINDOW,
                   max_width_change: RESET_MAX_WIDTH_CHANGE};
      pos_q = 16'd0;
      last_dir = LAST_NONE;
      cur_width = 12'(RESET_BASE_WIDTH);
      in_move = 1'b0;
      move_dir = 1'b0;
      step_idx = 16'd0;
      total_len = 16'd0;
      ramp_len = 12'd0;

      // The first rows run at reset values: idle tick, too-short move, move beyond one turn,
      // and a move of exactly one turn that wraps to zero length.
      dir_tab[0]  = '{ROW_ITEM, CMD_TICK,   16'h0000, CSR_SPARE_6, 8'd1, 1'b1, ZERO_RESULT};
      dir_tab[1]  = '{ROW_ITEM, CMD_TARGET, 16'h000A, CSR_SPARE_6, 8'd1, 1'b1, ZERO_RESULT};
      dir_tab[2]  = '{ROW_ITEM, CMD_TARGET, 16'hFFFF, CSR_SPARE_6, 8'd1, 1'b1, ZERO_RESULT};
      dir_tab[3]  = '{ROW_ITEM, CMD_TARGET, 16'h1900, CSR_SPARE_6, 8'd1, 1'b1,
                      EMPTY_MOVE_RESULT};
      dir_tab[4]  = '{ROW_ITEM, CMD_TICK,   16'h0000, CSR_SPARE_6, 8'd1, 1'b1, ZERO_RESULT};
      dir_tab[5]  = '{ROW_CSR,  CMD_TICK,   16'hFFFF, CSR_SPARE_6, 8'd1, 1'b0, ZERO_RESULT};
      dir_tab[6]  = '{ROW_CSR,  CMD_TICK,   16'hFFFF, CSR_SPARE_7, 8'd1, 1'b0, ZERO_RESULT};
      dir_tab[7]  = '{ROW_CSR,  CMD_TICK,   16'h000C, CSR_STEPS_PER_TURN, 8'd1, 1'b0,
                      ZERO_RESULT};
      dir_tab[8]  = '{ROW_CSR,  CMD_TICK,   16'h03FF, CSR_BASE_WIDTH, 8'd1, 1'b0,
                      ZERO_RESULT};
      dir_tab[9]  = '{ROW_CSR,  CMD_TICK,   16'h0FFF, CSR_ACCEL_LIMIT, 8'd1, 1'b0,
                      ZERO_RESULT};
      dir_tab[10] = '{ROW_CSR,  CMD_TICK,   16'h0002, CSR_MIN_MOVE, 8'd1, 1'b0, ZERO_RESULT};
      dir_tab[11] = '{ROW_CSR,  CMD_TICK,   16'h0004, CSR_REVERSAL_WINDOW, 8'd1, 1'b0,
                      ZERO_RESULT};
      dir_tab[12] = '{ROW_CSR,  CMD_TICK,   16'h03E8, CSR_MAX_WIDTH_CHANGE, 8'd1, 1'b0,
                      ZERO_RESULT};
      dir_tab[13] = '{ROW_ITEM, CMD_TARGET, 16'h0003, CSR_SPARE_6, 8'd1, 1'b0, ZERO_RESULT};
      dir_tab[14] = '{ROW_ITEM, CMD_TARGET, 16'h0005, CSR_SPARE_6, 8'd1, 1'b0, ZERO_RESULT};
      dir_tab[15] = '{ROW_ITEM, CMD_TICK,   16'h0000, CSR_SPARE_6, 8'd3, 1'b0, ZERO_RESULT};
      dir_tab[16] = '{ROW_ITEM, CMD_TARGET, 16'h0001, CSR_SPARE_6, 8'd1, 1'b0, ZERO_RESULT};
      dir_tab[17] = '{ROW_ITEM, CMD_TICK,   16'h0000, CSR_SPARE_6, 8'd4, 1'b0, ZERO_RESULT};
      dir_tab[18] = '{ROW_ITEM, CMD_TICK,   16'h0000, CSR_SPARE_6, 8'd1, 1'b0, ZERO_RESULT};

      phase_cfg[0] = '{steps_per_turn: 16'd64, base_width: 10'd100, accel_limit: 12'd8,
                       min_move: 10'd3, reversal_window: 12'd10, max_width_change: 10'd20};
      phase_cfg[1] = '{steps_per_turn: 16'd2, base_width: 10'd1, accel_limit: 12'd1,
                       min_move: 10'd1, reversal_window: 12'd0, max_width_change: 10'd1};
      phase_cfg[2] = '{steps_per_turn: 16'd1100, base_width: 10'd1023, accel_limit: 12'd4095,
                       min_move: 10'd1023, reversal_window: 12'd4095,
                       max_width_change: 10'd1023};
      phase_cfg[3] = '{steps_per_turn: 16'd65535, base_width: 10'd512, accel_limit: 12'd4095,
                       min_move: 10'd1, reversal_window: 12'd4095, max_width_change: 10'd1023};
      phase_cfg[4] = '{steps_per_turn: 16'd300, base_width: 10'd700, accel_limit: 12'd5,
                       min_move: 10'd2, reversal_window: 12'd50, max_width_change: 10'd3};
      phase_cfg[5] = '{steps_per_turn: RESET_STEPS_PER_TURN, base_width: RESET_BASE_WIDTH,
                       accel_limit: RESET_ACCEL_LIMIT, min_move: RESET_MIN_MOVE,
                       reversal_window: RESET_REVERSAL_WINDOW,
                       max_width_change: RESET_MAX_WIDTH_CHANGE};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            write_csr(dir_tab[i].csr_idx, dir_tab[i].word);
         end else begin
            for (r = 0; r < dir_tab[i].reps; r++)
               send_item(dir_tab[i].cmd, dir_tab[i].word, dir_tab[i].has_want,
                         dir_tab[i].want);
         end
      end

      for (ph = 0; ph < 6; ph++) begin
         pc = phase_cfg[ph];
         junk = 16'($urandom);
         write_csr(CSR_STEPS_PER_TURN, pc.steps_per_turn);
         write_csr(CSR_BASE_WIDTH, {junk[5:0], pc.base_width});
         write_csr(CSR_ACCEL_LIMIT, {junk[9:6], pc.accel_limit});
         write_csr(CSR_MIN_MOVE, {junk[15:10], pc.min_move});
         write_csr(CSR_REVERSAL_WINDOW, {junk[3:0], pc.reversal_window});
         write_csr(CSR_MAX_WIDTH_CHANGE, {junk[11:6], pc.max_width_change});
         idle_on = (ph != 3);
         kmax = (pc.steps_per_turn / 2 < 30) ? pc.steps_per_turn / 2 : 30;
         lo = (pc.min_move <= kmax) ? pc.min_move : 1;
         n = 0;
         while (n < PHASE_ITEMS || in_move) begin
            roll = $urandom_range(99);
            junk = 16'($urandom);
            if (in_move) begin
               if (roll < 88) begin
                  send_item(CMD_TICK, junk, 1'b0, ZERO_RESULT);
                  n++;
               end else begin
                  send_item(CMD_TARGET, junk, 1'b0, ZERO_RESULT);
               end
            end else if (roll < 65) begin
               k = $urandom_range(kmax, lo);
               if ($urandom_range(1) != 0)
                  send_item(CMD_TARGET, aim_target(int'(pc.steps_per_turn - k), k), 1'b0,
                            ZERO_RESULT);
               else
                  send_item(CMD_TARGET, aim_target(k, k), 1'b0, ZERO_RESULT);
               n++;
            end else if (roll < 80) begin
               send_item(CMD_TICK, junk, 1'b0, ZERO_RESULT);
            end else if (roll < 92 || pc.steps_per_turn > 256) begin
               k = $urandom_range(pc.min_move - 1, 0);
               send_item(CMD_TARGET, aim_target(k, k), 1'b0, ZERO_RESULT);
            end else begin
               send_item(CMD_TARGET, junk, 1'b0, ZERO_RESULT);
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (profile_q.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      if (fail_count == 0)
         $display("stepper_move_profile_core test passed");
      else
         $display("stepper_move_profile_core test failed");
      $finish;
   end

endmodule
